FILE: src/ebid_pkg.sv
// ----------------------------------------------------------------------------
// ebid_pkg
// Shared types and constants for the escape byte integer decoder.
// ----------------------------------------------------------------------------
package ebid_pkg;

  localparam int unsigned COUNT_BITS = 16;

  localparam logic [7:0] ESC_POS = 8'h7F;
  localparam logic [7:0] ESC_NEG = 8'h81;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_TRUNC    = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic               value_valid;
    logic signed [15:0] value;
    logic               stream_done;
    status_e            status;
  } out_item_t;

  // Equality of the running count and the 16-bit expected count, either width.
  function automatic logic count_matches(input logic [COUNT_BITS-1:0] count,
                                         input logic [15:0] expected);
    logic [32:0] a;
    logic [32:0] b;
    a = 33'(count);
    b = 33'(expected);
    return a == b;
  endfunction

endpackage

FILE: src/ebid_in_reg.sv
// ----------------------------------------------------------------------------
// ebid_in_reg
// Input register stage; takes a new byte when empty or whenever the held one moves on.
// ----------------------------------------------------------------------------
module ebid_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ebid_pkg::in_item_t in_item_i,
  input  logic               advance_i,
  output logic               valid_o,
  output ebid_pkg::in_item_t item_o
);

  logic               valid_q;
  logic               valid_d;
  ebid_pkg::in_item_t item_q;
  logic               ready;

  assign ready      = !valid_q || advance_i;
  assign in_stall_o = !ready;
  assign valid_d    = ready ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: src/ebid_decode.sv
// ----------------------------------------------------------------------------
// ebid_decode
// Phase machine and value decode for one byte; state moves when the byte does.
// ----------------------------------------------------------------------------
module ebid_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ebid_pkg::in_item_t  item_i,
  input  logic                advance_i,
  input  logic [15:0]         expected_count_i,
  output logic                has_result_o,
  output ebid_pkg::out_item_t result_o
);

  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic                            neg_q, neg_d;
  logic [7:0]                      high_q, high_d;
  logic [ebid_pkg::COUNT_BITS-1:0] count_q, count_d;
  logic [ebid_pkg::COUNT_BITS-1:0] count_bumped;
  logic                            have;
  logic [15:0]                     val;
  logic [15:0]                     word;
  logic [14:0]                     mag;
  logic [7:0]                      b;

  assign b    = item_i.code_byte;
  assign word = {high_q, b};
  assign mag  = word[15:1];

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    high_d  = high_q;
    have    = 1'b0;
    val     = '0;
    case (phase_q)
      PH_HIGH: begin
        high_d  = b;
        phase_d = PH_LOW;
      end
      PH_LOW: begin
        val     = neg_q ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
        have    = 1'b1;
        phase_d = PH_CODE;
        neg_d   = 1'b0;
      end
      default: begin
        if (b inside {ebid_pkg::ESC_POS, ebid_pkg::ESC_NEG}) begin
          neg_d   = (b == ebid_pkg::ESC_NEG);
          phase_d = PH_HIGH;
        end else begin
          val  = {{8{b[7]}}, b};
          have = 1'b1;
        end
      end
    endcase
  end

  // saturating count of decoded values
  assign count_bumped = (count_q == '1) ? count_q
                                        : count_q + ebid_pkg::COUNT_BITS'(1);
  assign count_d      = have ? count_bumped : count_q;

  always_comb begin
    result_o             = '0;
    result_o.value_valid = have;
    result_o.value       = val;
    result_o.stream_done = item_i.last_byte;
    result_o.status      = ebid_pkg::STATUS_OK;
    if (item_i.last_byte) begin
      if (phase_d inside {PH_HIGH, PH_LOW}) begin
        result_o.status = ebid_pkg::STATUS_TRUNC;
      end else if (!ebid_pkg::count_matches(count_d, expected_count_i)) begin
        result_o.status = ebid_pkg::STATUS_MISMATCH;
      end
    end
  end

  assign has_result_o = have || item_i.last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CODE;
      neg_q   <= 1'b0;
      high_q  <= '0;
      count_q <= '0;
    end else if (advance_i) begin
      if (item_i.last_byte) begin
        phase_q <= PH_CODE;
        neg_q   <= 1'b0;
        high_q  <= '0;
        count_q <= '0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        high_q  <= high_d;
        count_q <= count_d;
      end
    end
  end

endmodule

FILE: src/ebid_out_reg.sv
// ----------------------------------------------------------------------------
// ebid_out_reg
// Result register; refills in the same cycle the held item is taken.
// ----------------------------------------------------------------------------
module ebid_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  ebid_pkg::out_item_t item_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ebid_pkg::out_item_t out_item_o
);

  logic                valid_q;
  logic                valid_d;
  ebid_pkg::out_item_t item_q;

  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = ready_o ? load_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

FILE: src/escape_byte_integer_decoder.sv
// A byte is accepted into the input register, decoded combinationally, and its result is stored in the output register.
// Throughput: one byte per cycle while the output does not stall; the phase machine steps once per byte.
// Bytes that produce no result (escape and high byte, unless marked last) pass without output.
// Reset clears the phase, escape state, count, expected count and both stages.
// ----------------------------------------------------------------------------
// escape_byte_integer_decoder
// Escape-coded byte stream to signed integers, with end-of-stream count check.
// ----------------------------------------------------------------------------
module escape_byte_integer_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ebid_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ebid_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i
);

  logic [15:0]         expected_count_q;
  logic                stage_valid;
  ebid_pkg::in_item_t  stage_item;
  logic                advance;
  logic                load;
  logic                has_result;
  logic                out_ready;
  ebid_pkg::out_item_t result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_count_q <= '0;
    end else if (cfg_we_i) begin
      expected_count_q <= cfg_wdata_i;
    end
  end

  // byte leaves the input stage if it has no result or the result can be stored
  assign advance = stage_valid && (!has_result || out_ready);
  assign load    = stage_valid && has_result && out_ready;

  ebid_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  ebid_decode u_decode (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (stage_item),
    .advance_i        (advance),
    .expected_count_i (expected_count_q),
    .has_result_o     (has_result),
    .result_o         (result)
  );

  ebid_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .item_i      (result),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef ASSERT_OFF
  a_no_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.value_valid || out_item_o.stream_done))
    else $error("result carries neither value nor end of stream");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.value_valid |-> out_item_o.value == 16'sd0)
    else $error("value nonzero without value_valid");

  a_status_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.stream_done |-> out_item_o.status == ebid_pkg::STATUS_OK)
    else $error("status set before end of stream");

  a_trunc_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ebid_pkg::STATUS_TRUNC
      |-> !out_item_o.value_valid)
    else $error("truncated escape carries a value");

  a_zero_expect_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.stream_done && out_item_o.value_valid
      && expected_count_q == 16'd0
      |-> out_item_o.status == ebid_pkg::STATUS_MISMATCH)
    else $error("decoded value at end matched a zero expected count");
`endif

endmodule
